[src/telemetry_sentence_deframer_top_defines.svh]
// Assertion macros shared by the deframer RTL.
`ifndef TELEMETRY_SENTENCE_DEFRAMER_TOP_DEFINES_SVH
`define TELEMETRY_SENTENCE_DEFRAMER_TOP_DEFINES_SVH

// Checked only while the block is out of reset.
`define TSD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every edge, during reset as well.
`define TSD_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

[src/tsd_pkg.sv]
`default_nettype none

package tsd_pkg;

  // Register reset values.
  localparam logic [11:0] MaxLengthRst    = 12'd1000;
  localparam logic [7:0]  GarbageLimitRst = 8'd32;
  localparam logic [15:0] SilenceLimitRst = 16'd50;

  // CRC16-CCITT.
  localparam logic [15:0] CrcPoly = 16'h1021;
  localparam logic [15:0] CrcInit = 16'hFFFF;

  // Characters the parser looks for.
  localparam logic [7:0] ChDollar = 8'h24;
  localparam logic [7:0] ChCr     = 8'h0D;
  localparam logic [7:0] ChLf     = 8'h0A;
  localparam logic [7:0] ChHash   = 8'h23;
  localparam logic [7:0] ChStar   = 8'h2A;
  localparam logic [7:0] ChComma  = 8'h2C;
  localparam logic [7:0] PrintLo  = 8'h20;
  localparam logic [7:0] PrintHi  = 8'h7E;

  typedef enum logic {
    CmdByte = 1'b0,
    CmdSkip = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    CfgMaxLength    = 2'd0,
    CfgGarbageLimit = 2'd1,
    CfgSilenceLimit = 2'd2
  } cfg_reg_e;

  typedef enum logic [3:0] {
    StXorOk     = 4'd0,
    StCrcOk     = 4'd1,
    StNoCsum    = 4'd2,
    StBadLen    = 4'd3,
    StMismatch  = 4'd4,
    StEmptyCall = 4'd5,
    StTooLong   = 4'd6,
    StGarbage   = 4'd7,
    StSilence   = 4'd8
  } status_e;

  typedef struct packed {
    cmd_e       cmd;
    logic [7:0] byte_value;
    logic       baudot_hack;
    logic [7:0] skip_count;
  } item_t;

  typedef struct packed {
    status_e     status;
    logic [11:0] sentence_length;
    logic [15:0] computed_checksum;
  } result_t;

  // One byte of CRC16-CCITT, MSB first.
  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  // Uppercase ASCII hex digit of a nibble.
  function automatic logic [7:0] hex_digit(input logic [3:0] v);
    return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h37 + {4'h0, v});
  endfunction

  // Lowercase letters folded to upper case.
  function automatic logic [7:0] to_upper(input logic [7:0] c);
    return (c >= 8'h61 && c <= 8'h7A) ? (c - 8'd32) : c;
  endfunction

endpackage

`default_nettype wire

[src/tsd_in_reg.sv]
`default_nettype none

// Input register: holds one word until the parser takes it.
module tsd_in_reg (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          s_valid_i,
  output logic               s_ready_o,
  input  wire tsd_pkg::item_t item_i,
  input  wire logic          take_i,
  output logic               valid_o,
  output tsd_pkg::item_t     item_o
);

  logic           valid_q;
  tsd_pkg::item_t item_q;

  // Free when empty or when the held word leaves this cycle.
  assign s_ready_o = !valid_q || take_i;
  assign valid_o   = valid_q;
  assign item_o    = item_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (s_valid_i && s_ready_o) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_valid_i && s_ready_o) begin
      item_q <= item_i;
    end
  end

endmodule

`default_nettype wire

[src/tsd_core.sv]
`default_nettype none

// Sentence parser: state, checksums, limits and the verdict for one word.
module tsd_core (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  input  wire logic           cfg_valid_i,
  input  wire logic [1:0]     cfg_addr_i,
  input  wire logic [15:0]    cfg_data_i,
  input  wire logic           take_i,
  input  wire tsd_pkg::item_t item_i,
  output logic                res_valid_o,
  output tsd_pkg::result_t    res_o
);

  // Limit registers.
  logic [11:0] max_len_q;
  logic [7:0]  gar_lim_q;
  logic [15:0] sil_lim_q;

  // Sentence state.
  logic [7:0]  prev_q, prev_d;
  logic        in_sent_q, in_sent_d;
  logic [11:0] len_q, len_d;
  logic [7:0]  gar_q, gar_d;
  logic [15:0] sil_q, sil_d;
  logic [7:0]  xor_q, xor_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  xor_star_q, xor_star_d;
  logic [15:0] crc_star_q, crc_star_d;
  logic        star_q, star_d;
  logic [2:0]  cas_q, cas_d;
  logic [7:0]  dig_q [4];
  logic [7:0]  dig_d [4];
  logic [7:0]  fdb_q, fdb_d;
  logic        call_empty_q, call_empty_d;

  logic        clear, start;
  logic [7:0]  b_raw, b;
  logic [16:0] sil_sum;
  logic [12:0] len_inc;
  logic [11:0] len_sat;
  logic [8:0]  gar_inc;
  logic        is_garbage;
  logic        xor_match, crc_match;

  // Configuration writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= tsd_pkg::MaxLengthRst;
      gar_lim_q <= tsd_pkg::GarbageLimitRst;
      sil_lim_q <= tsd_pkg::SilenceLimitRst;
    end else if (cfg_valid_i) begin
      unique case (tsd_pkg::cfg_reg_e'(cfg_addr_i))
        tsd_pkg::CfgMaxLength:    max_len_q <= cfg_data_i[11:0];
        tsd_pkg::CfgGarbageLimit: gar_lim_q <= cfg_data_i[7:0];
        tsd_pkg::CfgSilenceLimit: sil_lim_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Common terms of the byte path.
  assign b_raw      = (item_i.byte_value == tsd_pkg::ChCr) ? tsd_pkg::ChLf : item_i.byte_value;
  assign b          = (item_i.baudot_hack && b_raw == tsd_pkg::ChHash) ? tsd_pkg::ChStar : b_raw;
  assign sil_sum    = {1'b0, sil_q} + {9'd0, item_i.skip_count};
  assign len_inc    = {1'b0, len_q} + 13'd1;
  assign len_sat    = len_inc[12] ? 12'hFFF : len_inc[11:0];
  assign gar_inc    = {1'b0, gar_q} + 9'd1;
  assign is_garbage = (b < tsd_pkg::PrintLo) || (b > tsd_pkg::PrintHi);

  // Received digits against the snapshots, case-insensitive.
  assign xor_match = (tsd_pkg::to_upper(dig_q[0]) == tsd_pkg::hex_digit(xor_star_q[7:4])) &&
                     (tsd_pkg::to_upper(dig_q[1]) == tsd_pkg::hex_digit(xor_star_q[3:0]));
  assign crc_match = (tsd_pkg::to_upper(dig_q[0]) == tsd_pkg::hex_digit(crc_star_q[15:12])) &&
                     (tsd_pkg::to_upper(dig_q[1]) == tsd_pkg::hex_digit(crc_star_q[11:8])) &&
                     (tsd_pkg::to_upper(dig_q[2]) == tsd_pkg::hex_digit(crc_star_q[7:4])) &&
                     (tsd_pkg::to_upper(dig_q[3]) == tsd_pkg::hex_digit(crc_star_q[3:0]));

  // Next state and verdict.
  always_comb begin
    prev_d       = prev_q;
    in_sent_d    = in_sent_q;
    len_d        = len_q;
    gar_d        = gar_q;
    sil_d        = sil_q;
    xor_d        = xor_q;
    crc_d        = crc_q;
    xor_star_d   = xor_star_q;
    crc_star_d   = crc_star_q;
    star_d       = star_q;
    cas_d        = cas_q;
    dig_d        = dig_q;
    fdb_d        = fdb_q;
    call_empty_d = call_empty_q;
    clear        = 1'b0;
    start        = 1'b0;
    res_valid_o  = 1'b0;
    res_o        = '0;

    if (take_i) begin
      if (item_i.cmd == tsd_pkg::CmdSkip) begin
        // Silence only counts inside a sentence.
        if (in_sent_q) begin
          sil_d = sil_sum[16] ? 16'hFFFF : sil_sum[15:0];
          if (sil_sum > {1'b0, sil_lim_q}) begin
            res_valid_o     = 1'b1;
            res_o.status    = tsd_pkg::StSilence;
            res_o.sentence_length = len_q;
            clear           = 1'b1;
          end
        end
      end else if (prev_q == tsd_pkg::ChDollar && b_raw == tsd_pkg::ChDollar) begin
        // Start pair: drop whatever was open and begin afresh.
        clear  = 1'b1;
        start  = 1'b1;
        prev_d = b_raw;
      end else if (!in_sent_q) begin
        prev_d = b_raw;
      end else if (b_raw == tsd_pkg::ChLf) begin
        // End of sentence: judge checksum and callsign.
        res_valid_o = 1'b1;
        res_o.sentence_length = len_sat;
        if (!star_q) begin
          res_o.status = tsd_pkg::StNoCsum;
        end else if (cas_q != 3'd2 && cas_q != 3'd4) begin
          res_o.status = tsd_pkg::StBadLen;
        end else if (cas_q == 3'd2) begin
          res_o.computed_checksum = {8'h00, xor_star_q};
          res_o.status = !xor_match ? tsd_pkg::StMismatch :
                         call_empty_q ? tsd_pkg::StEmptyCall : tsd_pkg::StXorOk;
        end else begin
          res_o.computed_checksum = crc_star_q;
          res_o.status = !crc_match ? tsd_pkg::StMismatch :
                         call_empty_q ? tsd_pkg::StEmptyCall : tsd_pkg::StCrcOk;
        end
        clear  = 1'b1;
        prev_d = b_raw;
      end else begin
        // Data byte.
        if (len_q == 12'd2) begin
          fdb_d = b;
        end
        if (b == tsd_pkg::ChStar) begin
          xor_star_d   = xor_q;
          crc_star_d   = crc_q;
          call_empty_d = (len_q == 12'd2) || (fdb_q == tsd_pkg::ChComma);
          star_d       = 1'b1;
          cas_d        = 3'd0;
          for (int i = 0; i < 4; i++) begin
            dig_d[i] = 8'h00;
          end
        end else if (star_q) begin
          if (cas_q < 3'd4) begin
            dig_d[cas_q[1:0]] = b;
          end
          if (cas_q < 3'd7) begin
            cas_d = cas_q + 3'd1;
          end
        end
        xor_d  = xor_q ^ b;
        crc_d  = tsd_pkg::crc_update(crc_q, b);
        len_d  = len_sat;
        if (is_garbage) begin
          gar_d = gar_inc[8] ? 8'hFF : gar_inc[7:0];
        end
        prev_d = b;
        if (len_inc > {1'b0, max_len_q}) begin
          res_valid_o = 1'b1;
          res_o.status = tsd_pkg::StTooLong;
          res_o.sentence_length = len_sat;
          clear = 1'b1;
        end else if (gar_d > gar_lim_q) begin
          res_valid_o = 1'b1;
          res_o.status = tsd_pkg::StGarbage;
          res_o.sentence_length = len_sat;
          clear = 1'b1;
        end
      end
    end

    // Sentence reset, then the start of a new one.
    if (clear) begin
      in_sent_d    = 1'b0;
      len_d        = 12'd0;
      gar_d        = 8'd0;
      sil_d        = 16'd0;
      xor_d        = 8'd0;
      crc_d        = tsd_pkg::CrcInit;
      xor_star_d   = 8'd0;
      crc_star_d   = tsd_pkg::CrcInit;
      star_d       = 1'b0;
      cas_d        = 3'd0;
      for (int i = 0; i < 4; i++) begin
        dig_d[i] = 8'h00;
      end
      fdb_d        = 8'd0;
      call_empty_d = 1'b0;
    end
    if (start) begin
      in_sent_d = 1'b1;
      len_d     = 12'd2;
    end
  end

  // State registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q       <= 8'd0;
      in_sent_q    <= 1'b0;
      len_q        <= 12'd0;
      gar_q        <= 8'd0;
      sil_q        <= 16'd0;
      xor_q        <= 8'd0;
      crc_q        <= tsd_pkg::CrcInit;
      xor_star_q   <= 8'd0;
      crc_star_q   <= tsd_pkg::CrcInit;
      star_q       <= 1'b0;
      cas_q        <= 3'd0;
      for (int i = 0; i < 4; i++) begin
        dig_q[i] <= 8'h00;
      end
      fdb_q        <= 8'd0;
      call_empty_q <= 1'b0;
    end else begin
      prev_q       <= prev_d;
      in_sent_q    <= in_sent_d;
      len_q        <= len_d;
      gar_q        <= gar_d;
      sil_q        <= sil_d;
      xor_q        <= xor_d;
      crc_q        <= crc_d;
      xor_star_q   <= xor_star_d;
      crc_star_q   <= crc_star_d;
      star_q       <= star_d;
      cas_q        <= cas_d;
      dig_q        <= dig_d;
      fdb_q        <= fdb_d;
      call_empty_q <= call_empty_d;
    end
  end

endmodule

`default_nettype wire

[src/tsd_out_reg.sv]
`default_nettype none

// Result register toward the master side.
module tsd_out_reg (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             take_i,
  input  wire logic             res_valid_i,
  input  wire tsd_pkg::result_t res_i,
  input  wire logic             m_ready_i,
  output logic                  m_valid_o,
  output tsd_pkg::result_t      res_o,
  output logic                  can_take_o
);

  logic             valid_q;
  tsd_pkg::result_t res_q;

  // A new result may land when the slot is empty or drains this cycle.
  assign can_take_o = !valid_q || m_ready_i;
  assign m_valid_o  = valid_q;
  assign res_o      = res_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (take_i && res_valid_i) begin
      valid_q <= 1'b1;
    end else if (m_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_i && res_valid_i) begin
      res_q <= res_i;
    end
  end

endmodule

`default_nettype wire

[src/telemetry_sentence_deframer_top.sv]
// Channel   Dir  Payload                                   Handshake
// s_axis    in   tuser: cmd; tdata: byte, hack, skip       tvalid/tready
// m_axis    out  tdata: status, length, checksum           tvalid/tready
// cfg       in   addr: register index; data: value         cfg_valid/cfg_ready
//
// One word per cycle while the result slot can take it: the input register feeds the parser, whose
// combinational update (CRC byte step included) writes the state and the result register.
// A result passes through the input register and then the result register before it is offered.
// Reset clears sentence state, the limits to their defaults and both valids.
// A stalled result holds the parser; the input register still takes one word.
// Configuration writes are always ready and take effect on the next cycle.
`default_nettype none

`include "telemetry_sentence_deframer_top_defines.svh"

module telemetry_sentence_deframer_top (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave side
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [23:0] s_axis_tdata_i,  // byte_value[7:0], baudot_hack[8], skip_count[16:9]
  input  wire logic        s_axis_tuser_i,  // cmd[0]
  // Master side
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [31:0]      m_axis_tdata_o,  // status[3:0], sentence_length[15:4],
                                            // computed_checksum[31:16]
  // Configuration
  input  wire logic        cfg_valid_i,
  output logic             cfg_ready_o,
  input  wire logic [1:0]  cfg_addr_i,
  input  wire logic [15:0] cfg_data_i
);

  tsd_pkg::item_t   in_item, held_item;
  tsd_pkg::result_t core_res, out_res;
  logic             in_valid, out_can, take, res_valid;
  logic             out_stall, csum_unchecked;

  assign in_item.cmd         = tsd_pkg::cmd_e'(s_axis_tuser_i);
  assign in_item.byte_value  = s_axis_tdata_i[7:0];
  assign in_item.baudot_hack = s_axis_tdata_i[8];
  assign in_item.skip_count  = s_axis_tdata_i[16:9];

  assign cfg_ready_o = 1'b1;

  // The parser moves a word whenever the result slot can take its outcome.
  assign take = in_valid && out_can;

  tsd_in_reg u_in_reg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .s_valid_i (s_axis_tvalid_i),
    .s_ready_o (s_axis_tready_o),
    .item_i    (in_item),
    .take_i    (take),
    .valid_o   (in_valid),
    .item_o    (held_item)
  );

  tsd_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_data_i  (cfg_data_i),
    .take_i      (take),
    .item_i      (held_item),
    .res_valid_o (res_valid),
    .res_o       (core_res)
  );

  tsd_out_reg u_out_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .take_i      (take),
    .res_valid_i (res_valid),
    .res_i       (core_res),
    .m_ready_i   (m_axis_tready_i),
    .m_valid_o   (m_axis_tvalid_o),
    .res_o       (out_res),
    .can_take_o  (out_can)
  );

  assign m_axis_tdata_o = {out_res.computed_checksum, out_res.sentence_length,
                           out_res.status};

  // Terms used by the checks below.
  assign out_stall      = m_axis_tvalid_o && !m_axis_tready_i;
  assign csum_unchecked = (out_res.status == tsd_pkg::StNoCsum) ||
                          (out_res.status == tsd_pkg::StBadLen) ||
                          (out_res.status >= tsd_pkg::StTooLong);

  // A full input register behind a stalled result accepts nothing more.
  `TSD_ASSERT(a_full_stall, (in_valid && out_stall) |-> !s_axis_tready_o, "input taken while blocked")

  // Verdicts without a checked checksum report zero.
  `TSD_ASSERT(a_zero_csum, (m_axis_tvalid_o && csum_unchecked) |-> (out_res.computed_checksum == 16'h0000), "nonzero checksum")

  // Status codes stay within the defined set.
  `TSD_ASSERT(a_status_range, m_axis_tvalid_o |-> (out_res.status <= tsd_pkg::StSilence), "undefined status code")

  // No result is offered while reset is asserted.
  `TSD_ASSERT_ALWAYS(a_reset_quiet, !rst_ni |-> !m_axis_tvalid_o, "result valid during reset")

endmodule

`default_nettype wire

[verif/testbench.sv]
module testbench;
  import tsd_pkg::*;

  localparam int unsigned NumPhases      = 6;
  localparam int unsigned RandomPerPhase = 175;
  localparam int unsigned SettleCycles   = 8;
  localparam int unsigned HoldCycles     = 80;
  localparam int unsigned StallLimit     = 4000;
  localparam int unsigned PrintCap       = 100;

  // Kinds of flawed sentence.
  localparam int unsigned FlawNone     = 0;
  localparam int unsigned FlawCut      = 1;
  localparam int unsigned FlawNoStar   = 2;
  localparam int unsigned FlawDigits   = 3;
  localparam int unsigned FlawBadDigit = 4;
  localparam int unsigned FlawQuiet    = 5;

  localparam result_t NoReport = '{StXorOk, 12'd0, 16'd0};

  // One opening word, with its report written out where it is obvious.
  typedef struct packed {
    item_t   word;
    bit      typed;
    result_t want;
  } opening_row_t;

  // Limits and idle percentages of one random phase.
  typedef struct packed {
    logic [11:0] len_lim;
    logic [7:0]  junk_lim;
    logic [15:0] quiet_lim;
    logic [6:0]  src_idle;
    logic [6:0]  sink_idle;
  } phase_t;

  localparam opening_row_t OpeningRows [28] = '{
    // Skip event and a stray byte outside any sentence are ignored.
    '{'{CmdSkip, 8'h00, 1'b1, 8'hFF}, 1'b0, NoReport},
    '{'{CmdByte, 8'hFF, 1'b0, 8'h00}, 1'b0, NoReport},
    // A third dollar sign restarts the sentence; newline without a star.
    '{'{CmdByte, ChDollar, 1'b0, 8'h5A}, 1'b0, NoReport},
    '{'{CmdByte, ChDollar, 1'b1, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChDollar, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChLf, 1'b0, 8'h00}, 1'b1, '{StNoCsum, 12'd3, 16'h0000}},
    // Star with no digits, closed by carriage return.
    '{'{CmdByte, ChDollar, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChDollar, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChStar, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChCr, 1'b0, 8'h00}, 1'b1, '{StBadLen, 12'd4, 16'h0000}},
    // A single long skip exceeds the default silence limit.
    '{'{CmdByte, ChDollar, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChDollar, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdSkip, 8'hFF, 1'b0, 8'hFF}, 1'b1, '{StSilence, 12'd2, 16'h0000}},
    // Hash taken as star, lowercase checksum digit.
    '{'{CmdByte, ChDollar, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChDollar, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, 8'h5A, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChHash, 1'b1, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, 8'h35, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, 8'h61, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChCr, 1'b1, 8'h00}, 1'b1, '{StXorOk, 12'd7, 16'h005A}},
    // Four digits over empty data: CRC init value, but the callsign is empty.
    '{'{CmdByte, ChDollar, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChDollar, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChStar, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, 8'h46, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, 8'h46, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, 8'h66, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, 8'h46, 1'b0, 8'h00}, 1'b0, NoReport},
    '{'{CmdByte, ChLf, 1'b0, 8'h00}, 1'b1, '{StEmptyCall, 12'd8, 16'hFFFF}}
  };

  localparam phase_t PhasePlan [NumPhases] = '{
    '{12'd4095, 8'd255, 16'd65535, 7'd13, 7'd66},
    '{12'd3,    8'd0,   16'd0,     7'd13, 7'd66},
    '{12'd40,   8'd4,   16'd20,    7'd66, 7'd13},
    '{12'd300,  8'd16,  16'd400,   7'd66, 7'd13},
    '{12'd12,   8'd1,   16'd5,     7'd0,  7'd0},
    '{12'd4095, 8'd100, 16'd1000,  7'd0,  7'd0}
  };

  // Block ports.
  logic        clk_i           = 1'b0;
  logic        rst_ni          = 1'b1;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [23:0] s_axis_tdata_i  = '0;
  logic        s_axis_tuser_i  = 1'b0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [31:0] m_axis_tdata_o;
  logic        cfg_valid_i     = 1'b0;
  logic        cfg_ready_o;
  logic [1:0]  cfg_addr_i      = '0;
  logic [15:0] cfg_data_i      = '0;

  // Predicted deframer state and limits.
  logic [7:0]  last_byte;
  bit          framing;
  logic [11:0] len_cnt;
  logic [7:0]  junk_cnt;
  logic [15:0] quiet_cnt;
  logic [7:0]  xor_acc;
  logic [15:0] crc_acc;
  logic [7:0]  xor_snap;
  logic [15:0] crc_snap;
  bit          star_found;
  logic [2:0]  digits_after;
  logic [7:0]  digit_buf [4];
  logic [7:0]  lead_byte;
  bit          no_callsign;
  logic [11:0] lim_length;
  logic [7:0]  lim_junk;
  logic [15:0] lim_quiet;

  // Reports predicted but not yet seen, oldest first.
  result_t     expected_reports [$];

  int unsigned src_idle_pct  = 13;
  int unsigned sink_idle_pct = 66;
  bit          hold_request  = 1'b0;
  int unsigned words_sent    = 0;
  int unsigned reports_seen  = 0;
  int unsigned mismatches    = 0;
  int unsigned status_seen [9];

  telemetry_sentence_deframer_top u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_addr_i      (cfg_addr_i),
    .cfg_data_i      (cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // CRC16-CCITT over one byte, MSB first.
  function automatic logic [15:0] crc16_step(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ((c << 1) ^ CrcPoly) : (c << 1);
    end
    return c;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib, input bit lower);
    if (nib < 4'd10) begin
      return 8'h30 + {4'h0, nib};
    end
    return (lower ? 8'h57 : 8'h37) + {4'h0, nib};
  endfunction

  // The received digits must spell the value, letters in either case.
  function automatic bit digits_agree(input logic [15:0] value, input int n);
    logic [7:0] got_ch;
    bit         ok;
    ok = 1'b1;
    for (int i = 0; i < n; i++) begin
      got_ch = digit_buf[i];
      if (got_ch >= 8'h61 && got_ch <= 8'h7A) got_ch = got_ch - 8'd32;
      if (got_ch != hex_char(4'(value >> (4 * (n - 1 - i))), 1'b0)) ok = 1'b0;
    end
    return ok;
  endfunction

  function automatic void drop_sentence();
    framing      = 1'b0;
    len_cnt      = '0;
    junk_cnt     = '0;
    quiet_cnt    = '0;
    xor_acc      = '0;
    crc_acc      = CrcInit;
    xor_snap     = '0;
    crc_snap     = CrcInit;
    star_found   = 1'b0;
    digits_after = '0;
    digit_buf    = '{default: 8'h00};
    lead_byte    = '0;
    no_callsign  = 1'b0;
  endfunction

  // Advances the predicted state by one word and gives the report it causes.
  task automatic deframe_predict(input item_t w, output bit emitted, output result_t r);
    logic [7:0]  b;
    int unsigned sum;
    int unsigned nlen;
    logic [11:0] len12;
    status_e     st;
    logic [15:0] ck;
    emitted = 1'b0;
    r       = NoReport;
    b       = w.byte_value;
    if (w.cmd == CmdSkip) begin
      if (framing) begin
        sum       = quiet_cnt + w.skip_count;
        quiet_cnt = (sum > 32'hFFFF) ? 16'hFFFF : 16'(sum);
        if (sum > lim_quiet) begin
          r       = '{StSilence, len_cnt, 16'h0000};
          emitted = 1'b1;
          drop_sentence();
        end
      end
    end else begin
      if (b == ChCr) b = ChLf;
      if (last_byte == ChDollar && b == ChDollar) begin
        drop_sentence();
        framing = 1'b1;
        len_cnt = 12'd2;
      end else if (framing && b == ChLf) begin
        // End of sentence: judge the checksum, then the callsign.
        ck = '0;
        if (!star_found) begin
          st = StNoCsum;
        end else if (digits_after != 3'd2 && digits_after != 3'd4) begin
          st = StBadLen;
        end else begin
          if (digits_after == 3'd2) begin
            ck = {8'h00, xor_snap};
            st = digits_agree(ck, 2) ? StXorOk : StMismatch;
          end else begin
            ck = crc_snap;
            st = digits_agree(ck, 4) ? StCrcOk : StMismatch;
          end
          if (st != StMismatch && no_callsign) st = StEmptyCall;
        end
        nlen    = len_cnt + 1;
        len12   = (nlen > 4095) ? 12'hFFF : 12'(nlen);
        r       = '{st, len12, ck};
        emitted = 1'b1;
        drop_sentence();
      end else if (framing) begin
        // Data byte inside a sentence.
        if (w.baudot_hack && b == ChHash) b = ChStar;
        if (len_cnt == 12'd2) lead_byte = b;
        if (b == ChStar) begin
          xor_snap     = xor_acc;
          crc_snap     = crc_acc;
          no_callsign  = (len_cnt == 12'd2) || (lead_byte == ChComma);
          star_found   = 1'b1;
          digits_after = '0;
          digit_buf    = '{default: 8'h00};
        end else if (star_found) begin
          if (digits_after < 3'd4) digit_buf[digits_after[1:0]] = b;
          if (digits_after < 3'd7) digits_after = digits_after + 3'd1;
        end
        xor_acc = xor_acc ^ b;
        crc_acc = crc16_step(crc_acc, b);
        nlen    = len_cnt + 1;
        len12   = (nlen > 4095) ? 12'hFFF : 12'(nlen);
        len_cnt = len12;
        if ((b < PrintLo || b > PrintHi) && junk_cnt != 8'hFF) junk_cnt = junk_cnt + 8'd1;
        if (nlen > lim_length) begin
          r       = '{StTooLong, len12, 16'h0000};
          emitted = 1'b1;
          drop_sentence();
        end else if (junk_cnt > lim_junk) begin
          r       = '{StGarbage, len12, 16'h0000};
          emitted = 1'b1;
          drop_sentence();
        end
      end
      last_byte = b;
    end
  endtask

  // Offers one word, waits for it to be taken and records its report.
  task automatic push_word(input item_t w, input bit typed, input result_t want);
    bit      taken;
    bit      emitted;
    result_t guess;
    while ($urandom_range(99) < src_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {7'd0, w.skip_count, w.baudot_hack, w.byte_value};
    s_axis_tuser_i  <= w.cmd;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready_o;
      @(posedge clk_i);
    end while (!taken);
    deframe_predict(w, emitted, guess);
    if (typed) begin
      expected_reports = {expected_reports, want};
    end else if (emitted) begin
      expected_reports = {expected_reports, guess};
    end
    words_sent++;
  endtask

  task automatic send_byte(input logic [7:0] b, input bit hack);
    push_word('{CmdByte, b, hack, 8'($urandom)}, 1'b0, NoReport);
  endtask

  task automatic send_skip(input logic [7:0] n);
    push_word('{CmdSkip, 8'($urandom), 1'($urandom), n}, 1'b0, NoReport);
  endtask

  // Mostly printable text; now and then a control or high byte.
  function automatic logic [7:0] text_char();
    logic [7:0] c;
    if ($urandom_range(24) == 0) begin
      c = ($urandom_range(1) != 0) ? 8'($urandom_range(8'h80, 8'hFF)) : 8'($urandom_range(0, 31));
      if (c == ChLf || c == ChCr) c = 8'h7F;
    end else begin
      c = 8'($urandom_range(PrintLo, PrintHi));
      if (c == ChDollar) c = 8'h25;
      if (c == ChStar) c = 8'h2B;
    end
    return c;
  endfunction

  // A sentence with random text and its true checksum, unless a flaw is
  // asked for: cut off, no star, a random digit count, a bad digit or a
  // long silence in the middle.
  task automatic send_sentence(input int unsigned body_len, input int unsigned flaw);
    logic [7:0]  xr;
    logic [15:0] cr;
    logic [7:0]  c;
    logic [15:0] sum;
    bit          use_crc;
    bit          hash_star;
    int unsigned nat;
    int unsigned ndig;
    logic [3:0]  nib;
    xr = '0;
    cr = CrcInit;
    send_byte(ChDollar, 1'($urandom));
    send_byte(ChDollar, 1'($urandom));
    for (int unsigned i = 0; i < body_len; i++) begin
      c = text_char();
      if (i == 0 && $urandom_range(9) == 0) c = ChComma;
      if ($urandom_range(29) == 0) c = ChStar;
      if ($urandom_range(15) == 0) send_skip(8'($urandom_range(0, 6)));
      if (flaw == FlawQuiet && i == body_len / 2) send_skip(8'($urandom));
      send_byte(c, (c == ChHash) ? 1'b0 : 1'($urandom));
      xr = xr ^ c;
      cr = crc16_step(cr, c);
    end
    if (flaw == FlawCut) return;
    if (flaw != FlawNoStar) begin
      hash_star = 1'($urandom);
      send_byte(hash_star ? ChHash : ChStar, hash_star | 1'($urandom));
      use_crc = 1'($urandom);
      sum     = use_crc ? cr : {8'h00, xr};
      nat     = use_crc ? 4 : 2;
      ndig    = (flaw == FlawDigits) ? $urandom_range(0, 9) : nat;
      for (int unsigned k = 0; k < ndig; k++) begin
        nib = (k < nat) ? 4'(sum >> (4 * (nat - 1 - k))) : 4'($urandom);
        c   = hex_char(nib, 1'($urandom));
        if (flaw == FlawBadDigit && k == 0) c = c ^ 8'h01;
        send_byte(c, 1'($urandom));
      end
    end
    send_byte(($urandom_range(1) != 0) ? ChLf : ChCr, 1'($urandom));
  endtask

  // Raw words of any kind, dollar signs a little more often.
  task automatic send_noise(input int unsigned n);
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(3) == 0) begin
        send_skip(8'($urandom));
      end else begin
        send_byte(($urandom_range(4) == 0) ? ChDollar : 8'($urandom), 1'($urandom));
      end
    end
  endtask

  task automatic run_random(input int unsigned quota);
    int unsigned first;
    int unsigned pick;
    int unsigned body;
    first = words_sent;
    while (words_sent - first < quota) begin
      pick = $urandom_range(99);
      body = ($urandom_range(7) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 12);
      if (pick < 70) begin
        send_sentence(body, FlawNone);
      end else if (pick < 85) begin
        send_sentence(body, $urandom_range(FlawCut, FlawQuiet));
      end else begin
        send_noise($urandom_range(1, 24));
      end
    end
  endtask

  // Waits until every report is in, then lets the pipeline drain.
  task automatic wait_idle();
    while (expected_reports.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes all three limits; upper data bits beyond a field are don't care.
  task automatic write_limits(input phase_t ph);
    cfg_reg_e    regs [3];
    logic [15:0] vals [3];
    bit          taken;
    regs = '{CfgMaxLength, CfgGarbageLimit, CfgSilenceLimit};
    vals = '{{4'($urandom), ph.len_lim}, {8'($urandom), ph.junk_lim}, ph.quiet_lim};
    for (int i = 0; i < 3; i++) begin
      cfg_valid_i <= 1'b1;
      cfg_addr_i  <= regs[i];
      cfg_data_i  <= vals[i];
      do begin
        @(negedge clk_i);
        taken = cfg_ready_o;
        @(posedge clk_i);
      end while (!taken);
    end
    cfg_valid_i <= 1'b0;
    lim_length = ph.len_lim;
    lim_junk   = ph.junk_lim;
    lim_quiet  = ph.quiet_lim;
  endtask

  task automatic check_field(input string name, input int unsigned want, input int unsigned got);
    if (want != got) begin
      if (mismatches < PrintCap) begin
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
      end
      mismatches++;
    end
  endtask

  // Result sink: random backpressure, plus one long hold when requested.
  initial begin : result_sink
    int unsigned hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HoldCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready_i <= 1'b0;
      end else begin
        m_axis_tready_i <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  // Outputs are stable at the falling edge; a word seen here is taken next edge.
  always @(negedge clk_i) begin : report_check
    result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      reports_seen++;
      if (m_axis_tdata_o[3:0] < 4'd9) status_seen[m_axis_tdata_o[3:0]]++;
      if (expected_reports.size() == 0) begin
        if (mismatches < PrintCap) begin
          $display("%0t: report with none pending, expected nothing, actual %h",
                   $time, m_axis_tdata_o);
        end
        mismatches++;
      end else begin
        want = expected_reports.pop_front();
        check_field("status", want.status, m_axis_tdata_o[3:0]);
        check_field("sentence_length", want.sentence_length, m_axis_tdata_o[15:4]);
        check_field("computed_checksum", want.computed_checksum, m_axis_tdata_o[31:16]);
      end
    end
  end

  // Watchdog: ends the run when no channel moves for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < StallLimit) begin
      @(negedge clk_i);
      if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i) ||
          (cfg_valid_i && cfg_ready_o)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("%0t: no handshake for %0d cycles, %0d reports outstanding",
             $time, StallLimit, expected_reports.size());
    $display("FAIL telemetry_sentence_deframer_top");
    $finish;
  end

  initial begin : stimulus
    phase_t ph;
    rst_ni      <= 1'b0;
    status_seen = '{default: 0};
    last_byte   = '0;
    drop_sentence();
    lim_length  = MaxLengthRst;
    lim_junk    = GarbageLimitRst;
    lim_quiet   = SilenceLimitRst;

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed opening at the reset limits.
    foreach (OpeningRows[i]) begin
      push_word(OpeningRows[i].word, OpeningRows[i].typed, OpeningRows[i].want);
    end
    s_axis_tvalid_i <= 1'b0;

    for (int p = 0; p < NumPhases; p++) begin
      ph = PhasePlan[p];
      wait_idle();
      write_limits(ph);
      src_idle_pct  = ph.src_idle;
      sink_idle_pct = ph.sink_idle;
      if (p == 0) begin
        // Garbage tally saturates under the widest limit.
        send_byte(ChDollar, 1'b0);
        send_byte(ChDollar, 1'b0);
        repeat (270) send_byte(8'($urandom_range(8'h80, 8'hFF)), 1'($urandom));
        send_byte(ChLf, 1'b0);
        // Silence tally passes the widest limit, and the skip that carries it over aborts.
        send_byte(ChDollar, 1'b0);
        send_byte(ChDollar, 1'b0);
        repeat (260) send_skip(8'hFF);
      end
      if (p == 4) hold_request = 1'b1;
      run_random(RandomPerPhase);
      s_axis_tvalid_i <= 1'b0;
    end
    wait_idle();

    $display("Run covered %0d input words and %0d reports over %0d limit settings.",
             words_sent, reports_seen, NumPhases + 1);
    $display("Reports per status 0..8: %0d %0d %0d %0d %0d %0d %0d %0d %0d",
             status_seen[0], status_seen[1], status_seen[2], status_seen[3],
             status_seen[4], status_seen[5], status_seen[6], status_seen[7],
             status_seen[8]);
    if (mismatches == 0) begin
      $display("PASS telemetry_sentence_deframer_top");
    end else begin
      $display("FAIL telemetry_sentence_deframer_top");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+src
src/tsd_pkg.sv
src/tsd_in_reg.sv
src/tsd_core.sv
src/tsd_out_reg.sv
src/telemetry_sentence_deframer_top.sv
verif/testbench.sv
